// ----- hw/rtl/xadp_pkg.sv -----
// Shared types and constants for the XOR archive directory parser.
`default_nettype none

package xadp_pkg;

   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int SUM_W           = 42;
   localparam int SIZE_W          = 32;
   localparam int TIME_W          = 64;
   localparam int INDEX_OUT_W     = 10;

   localparam logic [7:0]  XOR_KEY_RST  = 8'hF7;
   localparam logic [63:0] MAGIC_RST    = 64'h0000_0000_BAC0_4AC0;
   localparam logic [7:0]  STATUS_NEXT  = 8'h00;
   localparam logic [7:0]  STATUS_END   = 8'h80;

   // phase codes double as the region codes of directory bytes
   typedef enum logic [2:0] {
      PH_MAGIC   = 3'd0,
      PH_STATUS  = 3'd1,
      PH_NAMELEN = 3'd2,
      PH_NAME    = 3'd3,
      PH_SIZE    = 3'd4,
      PH_TIME    = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_FULL    = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      OUT_OK            = 3'd0,
      OUT_BAD_SEP       = 3'd1,
      OUT_SIZE_MISMATCH = 3'd2,
      OUT_TOO_MANY      = 3'd3,
      OUT_TRUNCATED     = 3'd4
   } outcome_type;

   typedef enum logic [0:0] {
      CSR_XOR_KEY = 1'b0,
      CSR_MAGIC   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0]             plain_byte;
      logic [2:0]             region;
      logic [INDEX_OUT_W-1:0] entry_index;
      logic                   entry_done;
      logic [SIZE_W-1:0]      entry_size;
      logic [TIME_W-1:0]      entry_time;
      logic                   payload_last;
      logic                   magic_ok;
      logic                   finished;
      logic [2:0]             outcome;
   } rsp_type;

   // control from the parser to the file walker, one word per cycle
   typedef struct packed {
      logic clear;   // archive ends: forget all files
      logic append;  // record with nonzero size completes
      logic start;   // directory ends: fetch first file
      logic step;    // payload word consumed
   } walk_ctl_type;

   typedef struct packed {
      logic vld;     // a file with bytes left is current
      logic last;    // current file has one byte left
   } walk_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/xadp_file_walk.sv -----
// File table memory and payload file walker with one-entry read prefetch.
`default_nettype none

module xadp_file_walk
   import xadp_pkg::*;
#(
   parameter int  MAX_ENTRIES = MAX_ENTRIES_DEF,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 2)
) (
   input  logic                clock,
   input  logic                reset,
   input  walk_ctl_type        ctl,
   input  logic [IDX_W-1:0]    add_idx,
   input  logic [SIZE_W-1:0]   add_size,
   output walk_sts_type        sts,
   output logic [IDX_W-1:0]    file_idx
);

   localparam int ENT_W = IDX_W + SIZE_W;

   // only nonzero-size records are stored, packed in order with their record index
   logic [ENT_W-1:0]  mem [MAX_ENTRIES];
   logic [ENT_W-1:0]  rd_q_ff;

   logic [CNT_W-1:0]  nz_cnt_ff, nz_cnt_in;
   logic [CNT_W-1:0]  fetch_ff, fetch_in;
   logic              pend_ff, pend_in;        // current file comes from rd_q
   logic              pend_vld_ff, pend_vld_in;
   logic              cur_vld_ff, cur_vld_in;
   logic [IDX_W-1:0]  cur_idx_ff, cur_idx_in;
   logic [SIZE_W-1:0] cur_left_ff, cur_left_in;

   logic              eff_vld;
   logic [IDX_W-1:0]  eff_idx;
   logic [SIZE_W-1:0] eff_left;
   logic              eff_last;
   logic              advance;

   assign eff_vld  = pend_ff ? pend_vld_ff : cur_vld_ff;
   assign eff_idx  = pend_ff ? rd_q_ff[ENT_W-1:SIZE_W] : cur_idx_ff;
   assign eff_left = pend_ff ? rd_q_ff[SIZE_W-1:0] : cur_left_ff;
   assign eff_last = (eff_left == SIZE_W'(1));
   assign advance  = ctl.start | (ctl.step & eff_vld & eff_last);

   assign sts.vld  = eff_vld;
   assign sts.last = eff_last;
   assign file_idx = eff_idx;

   always_comb begin
      nz_cnt_in   = nz_cnt_ff;
      fetch_in    = fetch_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      cur_vld_in  = cur_vld_ff;
      cur_idx_in  = cur_idx_ff;
      cur_left_in = cur_left_ff;
      if (ctl.clear) begin
         nz_cnt_in   = '0;
         fetch_in    = '0;
         pend_in     = 1'b0;
         pend_vld_in = 1'b0;
         cur_vld_in  = 1'b0;
      end else begin
         if (ctl.append) begin
            nz_cnt_in = nz_cnt_ff + CNT_W'(1);
         end
         if (advance) begin
            fetch_in    = fetch_ff + CNT_W'(1);
            pend_in     = 1'b1;
            pend_vld_in = (fetch_ff < nz_cnt_ff);
         end else if (ctl.step) begin
            pend_in     = 1'b0;
            cur_vld_in  = eff_vld;
            cur_idx_in  = eff_idx;
            cur_left_in = eff_left - SIZE_W'(1);
         end
      end
   end

   // writes only happen before the payload starts, so reads never see a same-entry write
   always_ff @(posedge clock) begin
      if (ctl.append) begin
         mem[nz_cnt_ff[IDX_W-1:0]] <= {add_idx, add_size};
      end
      if (advance) begin
         rd_q_ff <= mem[fetch_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_cnt_ff   <= '0;
         fetch_ff    <= '0;
         pend_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
         cur_vld_ff  <= 1'b0;
      end else begin
         nz_cnt_ff   <= nz_cnt_in;
         fetch_ff    <= fetch_in;
         pend_ff     <= pend_in;
         pend_vld_ff <= pend_vld_in;
         cur_vld_ff  <= cur_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff  <= cur_idx_in;
      cur_left_ff <= cur_left_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/xor_archive_directory_parser.sv -----
// Top level of the XOR archive directory parser: byte decoder, record parser, output buffer.
`default_nettype none

// One archive byte is taken per word on req_* and exactly one result word
// leaves on rsp_* for it, in order. The block sustains one byte per clock while
// rsp_stall is low: the parser decides each byte combinationally and the result
// is registered. A two-word output buffer lets the block take the next byte
// while a result is stalled; req_stall rises only when both words are held. Each
// directory record with a nonzero size is stored in a file table memory
// (MAX_ENTRIES deep, one write and one read per cycle); during payload the next
// file is fetched as the last byte of the current one is taken, so files of
// any size, zero-size ones included, keep the one-byte-per-clock pace. The table
// needs no clearing pass: an entry count marks what is valid. The word with
// end_of_input carries the archive outcome and returns all parse state to its
// reset values; xor_key and expected_magic stay. Write csr_* only while no byte
// is in flight; csr_ready is always high.
module xor_archive_directory_parser
   import xadp_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   // byte input
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   // result output
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   // register writes
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [63:0]   csr_data
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int REC_W = $clog2(MAX_ENTRIES + 1);

   // ---------------------------------------------------------------- registers
   logic [7:0]  key_ff;
   logic [63:0] magic_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= XOR_KEY_RST;
         magic_ff <= MAGIC_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_XOR_KEY: key_ff   <= csr_data[7:0];
            CSR_MAGIC:   magic_ff <= csr_data;
            default:     key_ff   <= key_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- parse state
   phase_type         phase_ff, phase_step, phase_in;
   logic [2:0]        field_ff, field_in;        // byte within magic, size or time
   logic              match_ff, match_in;
   logic [7:0]        name_left_ff, name_left_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [REC_W-1:0]  rec_cnt_ff, rec_cnt_in;
   logic [SUM_W-1:0]  size_sum_ff, size_sum_in;
   logic [SUM_W-1:0]  pay_cnt_ff, pay_cnt_step, pay_cnt_in;
   logic              warn_ff, warn_step, warn_in;

   logic              acc;
   logic              last;
   logic [7:0]        plain;
   logic              magic_miss;
   logic              rec_done;
   logic              list_end;
   walk_ctl_type      walk_ctl;
   walk_sts_type      walk_sts;
   logic [IDX_W-1:0]  walk_idx;
   rsp_type           rsp_in;

   assign acc        = req_valid && !req_stall;
   assign last       = req_data.end_of_input;
   assign plain      = req_data.in_byte ^ key_ff;
   assign magic_miss = (magic_ff[{field_ff, 3'b000} +: 8] != plain);
   assign rec_done   = (phase_ff == PH_TIME) && (field_ff == 3'd7);
   assign list_end   = (phase_ff == PH_STATUS) && (plain != STATUS_NEXT);

   // next phase
   always_comb begin
      phase_step = phase_ff;
      unique case (phase_ff)
         PH_MAGIC: begin
            if (field_ff == 3'd7) phase_step = PH_STATUS;
         end
         PH_STATUS: begin
            if (plain != STATUS_NEXT) begin
               phase_step = PH_PAYLOAD;
            end else if (rec_cnt_ff >= REC_W'(MAX_ENTRIES)) begin
               phase_step = PH_FULL;
            end else begin
               phase_step = PH_NAMELEN;
            end
         end
         PH_NAMELEN: begin
            phase_step = (plain == 8'd0) ? PH_SIZE : PH_NAME;
         end
         PH_NAME: begin
            if (name_left_ff == 8'd1) phase_step = PH_SIZE;
         end
         PH_SIZE: begin
            if (field_ff == 3'd3) phase_step = PH_TIME;
         end
         PH_TIME: begin
            if (field_ff == 3'd7) phase_step = PH_STATUS;
         end
         PH_PAYLOAD: phase_step = PH_PAYLOAD;
         PH_FULL:    phase_step = PH_FULL;
         default:    phase_step = PH_FULL;
      endcase
      phase_in = phase_ff;
      if (acc) begin
         phase_in = last ? PH_MAGIC : phase_step;
      end
   end

   // datapath updates and the result word
   always_comb begin
      logic [REC_W+INDEX_OUT_W-1:0] rec_wide;
      logic [IDX_W+INDEX_OUT_W-1:0] file_wide;

      rec_wide  = {{INDEX_OUT_W{1'b0}}, rec_cnt_ff};
      file_wide = {{INDEX_OUT_W{1'b0}}, walk_idx};

      field_in     = field_ff;
      match_in     = match_ff;
      name_left_in = name_left_ff;
      size_in      = size_ff;
      time_in      = time_ff;
      rec_cnt_in   = rec_cnt_ff;
      size_sum_in  = size_sum_ff;
      pay_cnt_step = pay_cnt_ff;
      warn_step    = warn_ff;

      rsp_in              = '0;
      rsp_in.plain_byte   = plain;
      rsp_in.region       = phase_ff;
      rsp_in.finished     = last;

      unique case (phase_ff)
         PH_MAGIC: begin
            if (magic_miss) match_in = 1'b0;
            field_in = field_ff + 3'd1;
         end
         PH_STATUS: begin
            rsp_in.entry_index = rec_wide[INDEX_OUT_W-1:0];
            if (list_end && (plain != STATUS_END)) warn_step = 1'b1;
         end
         PH_NAMELEN: begin
            rsp_in.entry_index = rec_wide[INDEX_OUT_W-1:0];
            name_left_in       = plain;
         end
         PH_NAME: begin
            rsp_in.entry_index = rec_wide[INDEX_OUT_W-1:0];
            name_left_in       = name_left_ff - 8'd1;
         end
         PH_SIZE: begin
            rsp_in.entry_index = rec_wide[INDEX_OUT_W-1:0];
            size_in            = {plain, size_ff[SIZE_W-1:8]};
            field_in           = (field_ff == 3'd3) ? 3'd0 : field_ff + 3'd1;
         end
         PH_TIME: begin
            rsp_in.entry_index = rec_wide[INDEX_OUT_W-1:0];
            time_in            = {plain, time_ff[TIME_W-1:8]};
            field_in           = field_ff + 3'd1;
            if (rec_done) begin
               rsp_in.entry_done = 1'b1;
               rsp_in.entry_size = size_ff;
               rsp_in.entry_time = time_in;
               rec_cnt_in        = rec_cnt_ff + REC_W'(1);
               size_sum_in       = size_sum_ff + SUM_W'(size_ff);
            end
         end
         PH_PAYLOAD: begin
            pay_cnt_step = pay_cnt_ff + SUM_W'(1);
            if (walk_sts.vld) begin
               rsp_in.entry_index  = file_wide[INDEX_OUT_W-1:0];
               rsp_in.payload_last = walk_sts.last;
            end else begin
               rsp_in.region = PH_FULL;   // bytes past the last file
            end
         end
         PH_FULL: begin
            rsp_in.region = PH_FULL;
         end
         default: begin
            rsp_in.region = PH_FULL;
         end
      endcase

      rsp_in.magic_ok = match_in;

      if (last) begin
         if (phase_step == PH_FULL) begin
            rsp_in.outcome = OUT_TOO_MANY;
         end else if (phase_step != PH_PAYLOAD) begin
            rsp_in.outcome = OUT_TRUNCATED;
         end else if (size_sum_ff != pay_cnt_step) begin
            rsp_in.outcome = OUT_SIZE_MISMATCH;
         end else if (warn_step) begin
            rsp_in.outcome = OUT_BAD_SEP;
         end else begin
            rsp_in.outcome = OUT_OK;
         end
      end

      pay_cnt_in = pay_cnt_step;
      warn_in    = warn_step;

      // end of archive: back to reset values
      if (last) begin
         field_in     = '0;
         match_in     = 1'b1;
         name_left_in = '0;
         rec_cnt_in   = '0;
         size_sum_in  = '0;
         pay_cnt_in   = '0;
         warn_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         field_ff     <= '0;
         match_ff     <= 1'b1;
         name_left_ff <= '0;
         rec_cnt_ff   <= '0;
         size_sum_ff  <= '0;
         pay_cnt_ff   <= '0;
         warn_ff      <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (acc) begin
            field_ff     <= field_in;
            match_ff     <= match_in;
            name_left_ff <= name_left_in;
            rec_cnt_ff   <= rec_cnt_in;
            size_sum_ff  <= size_sum_in;
            pay_cnt_ff   <= pay_cnt_in;
            warn_ff      <= warn_in;
         end
      end
   end

   // size and time shift in all their bytes, so they need no clear
   always_ff @(posedge clock) begin
      if (acc) begin
         size_ff <= size_in;
         time_ff <= time_in;
      end
   end

   // ---------------------------------------------------------------- file table
   always_comb begin
      walk_ctl.clear  = acc && last;
      walk_ctl.append = acc && rec_done && (size_ff != '0);
      walk_ctl.start  = acc && list_end;
      walk_ctl.step   = acc && (phase_ff == PH_PAYLOAD);
   end

   xadp_file_walk #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_file_walk (
      .clock    (clock),
      .reset    (reset),
      .ctl      (walk_ctl),
      .add_idx  (rec_cnt_ff[IDX_W-1:0]),
      .add_size (size_ff),
      .sts      (walk_sts),
      .file_idx (walk_idx)
   );

   // ---------------------------------------------------------------- output buffer
   rsp_type out_ff, skid_ff;
   logic    out_vld_ff, out_vld_in;
   logic    skid_vld_ff, skid_vld_in;
   logic    pop;

   assign pop       = out_vld_ff && !rsp_stall;
   assign req_stall = skid_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      priority if (pop && skid_vld_ff) begin
         skid_vld_in = 1'b0;
      end else if (acc && (!out_vld_ff || pop)) begin
         out_vld_in = 1'b1;
      end else if (acc) begin
         skid_vld_in = 1'b1;
      end else if (pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_vld_ff) begin
         out_ff <= skid_ff;
      end else if (acc && (!out_vld_ff || pop)) begin
         out_ff <= rsp_in;
      end
      if (acc && out_vld_ff && !pop) begin
         skid_ff <= rsp_in;
      end
   end

   // ---------------------------------------------------------------- checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid word held without an output word");

   a_rec_bound: assert property (@(posedge clock) disable iff (reset)
      rec_cnt_ff <= REC_W'(MAX_ENTRIES))
      else $error("record count beyond table depth");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (acc && last) |=> (phase_ff == PH_MAGIC) && (rec_cnt_ff == '0) && (pay_cnt_ff == '0))
      else $error("parse state not cleared after last byte");

   a_payload_last_in_payload: assert property (@(posedge clock) disable iff (reset)
      (acc && rsp_in.payload_last) |-> (phase_ff == PH_PAYLOAD) && walk_sts.vld)
      else $error("file end flagged outside payload");

endmodule

`default_nettype wire

// ----- dv/xor_archive_directory_parser_test.sv -----
// Self-checking testbench for the XOR archive directory parser: random archives and a bit-exact byte decoder.
module xor_archive_directory_parser_test
   import xadp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int CYCLE_LIMIT      = 200_000;   // far above the slowest legal run
   localparam int RANDOM_PER_PHASE = 100;       // four random phases plus the directed set,
                                                // about 750 words in all
   localparam int HOLD_CYCLES      = 300;       // long receiver hold-off
   localparam int DRAIN_CYCLES     = 4;         // covers the two-word output buffer
   localparam int PAY_CAP          = 96;        // payload bytes emitted for huge size fields
   localparam int MAGIC_LEN        = 8;
   localparam int SIZE_LEN         = 4;
   localparam int STAMP_LEN        = 8;

   // how a generated directory list is closed
   typedef enum int {
      LIST_CLEAN,   // status 0x80
      LIST_BAD_SEP, // any other nonzero status
      LIST_MORE     // one more status 0, then junk
   } list_end_type;

   // ---------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // ---------------------------------------------------------------
   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   req_type       req_data    = '0;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid   = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index   = CSR_XOR_KEY;
   logic [63:0]   csr_data    = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   xor_archive_directory_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------
   // bookkeeping
   // ---------------------------------------------------------------
   req_type     archive_bytes_q[$];  // words waiting for the driver
   rsp_type     decoded_bytes_q[$];  // decoded results not yet seen on rsp_*
   logic [31:0] dir_sizes[$];        // size fields of the next generated archive
   logic [7:0]  gen_key   = XOR_KEY_RST;
   logic [63:0] gen_magic = MAGIC_RST;
   int          error_count     = 0;
   int          cycle_count     = 0;
   int          results_checked = 0;
   int          bytes_queued    = 0;
   int          archive_count   = 0;
   int          settings_used   = 1;
   int          outcome_seen[0:7];
   logic        req_taken       = 1'b0;
   logic        hold_request    = 1'b0;
   logic        hold_on         = 1'b0;
   rsp_type     got_word;
   rsp_type     want_word;

   // ---------------------------------------------------------------
   // decoder state: the parser as this testbench sees it
   // ---------------------------------------------------------------
   logic [7:0]  dec_key;
   logic [63:0] dec_magic;
   phase_type   dec_phase;
   logic [3:0]  dec_count;      // byte position inside magic, size or stamp
   logic        dec_magic_ok;
   logic [7:0]  dec_name_left;
   logic [31:0] dec_size;
   logic [63:0] dec_stamp;
   logic [10:0] dec_records;
   logic [31:0] dec_file_size[0:MAX_ENTRIES_DEF-1]; // only entries below dec_records are read
   logic [41:0] dec_size_sum;
   logic [41:0] dec_paid;       // payload bytes seen, wraps at 42 bits
   logic [10:0] dec_file;
   logic [31:0] dec_file_left;
   logic        dec_warn;

   function automatic void clear_parse_state();
      dec_phase     = PH_MAGIC;
      dec_count     = '0;
      dec_magic_ok  = 1'b1;
      dec_name_left = '0;
      dec_size      = '0;
      dec_stamp     = '0;
      dec_records   = '0;
      dec_size_sum  = '0;
      dec_paid      = '0;
      dec_file      = '0;
      dec_file_left = '0;
      dec_warn      = 1'b0;
   endfunction

   // skip zero-size files and load the length of the next one that holds bytes
   function automatic void seek_next_file();
      while (dec_file < dec_records && dec_file < MAX_ENTRIES_DEF &&
             dec_file_size[dec_file] == 32'd0)
         dec_file++;
      if (dec_file < dec_records && dec_file < MAX_ENTRIES_DEF)
         dec_file_left = dec_file_size[dec_file];
      else
         dec_file_left = '0;
   endfunction

   // decode one accepted archive word into the result word it must produce
   task automatic decode_archive_byte(input req_type w, output rsp_type r);
      logic [7:0]  p;
      phase_type   region_code;
      logic [10:0] idx;
      logic        done;
      logic        plast;
      logic [31:0] esize;
      logic [63:0] estamp;
      outcome_type oc;
      p           = w.in_byte ^ dec_key;
      region_code = dec_phase;
      idx         = '0;
      done        = 1'b0;
      plast       = 1'b0;
      esize       = '0;
      estamp      = '0;
      oc          = OUT_OK;
      case (dec_phase)
         PH_MAGIC: begin
            // a wrong header byte only drops the flag, parsing goes on
            if (dec_magic[8*dec_count[2:0] +: 8] != p)
               dec_magic_ok = 1'b0;
            dec_count++;
            if (dec_count >= MAGIC_LEN) begin
               dec_count = '0;
               dec_phase = PH_STATUS;
            end
         end
         PH_STATUS: begin
            idx = dec_records;
            if (p == STATUS_NEXT) begin
               if (dec_records >= MAX_ENTRIES_DEF) begin
                  dec_phase = PH_FULL;
               end else begin
                  dec_phase = PH_NAMELEN;
                  dec_count = '0;
                  dec_size  = '0;
                  dec_stamp = '0;
               end
            end else begin
               if (p != STATUS_END)
                  dec_warn = 1'b1;
               dec_phase = PH_PAYLOAD;
               dec_file  = '0;
               seek_next_file();
            end
         end
         PH_NAMELEN: begin
            idx           = dec_records;
            dec_name_left = p;
            dec_phase     = (p == 8'd0) ? PH_SIZE : PH_NAME;
         end
         PH_NAME: begin
            idx           = dec_records;
            dec_name_left = dec_name_left - 8'd1;
            if (dec_name_left == 8'd0)
               dec_phase = PH_SIZE;
         end
         PH_SIZE: begin
            idx      = dec_records;
            dec_size = dec_size | (32'(p) << (8 * dec_count[1:0]));
            dec_count++;
            if (dec_count >= SIZE_LEN) begin
               dec_count = '0;
               dec_phase = PH_TIME;
            end
         end
         PH_TIME: begin
            idx       = dec_records;
            dec_stamp = dec_stamp | (64'(p) << (8 * dec_count[2:0]));
            dec_count++;
            if (dec_count >= STAMP_LEN) begin
               dec_count = '0;
               done      = 1'b1;
               esize     = dec_size;
               estamp    = dec_stamp;
               if (dec_records < MAX_ENTRIES_DEF)
                  dec_file_size[dec_records] = dec_size;
               dec_size_sum = dec_size_sum + 42'(dec_size);
               dec_records++;
               dec_phase = PH_STATUS;
            end
         end
         PH_PAYLOAD: begin
            dec_paid = dec_paid + 42'd1;
            if (dec_file < dec_records && dec_file_left != 32'd0) begin
               idx = dec_file;
               dec_file_left--;
               if (dec_file_left == 32'd0) begin
                  plast = 1'b1;
                  dec_file++;
                  seek_next_file();
               end
            end else begin
               region_code = PH_FULL; // excess payload
            end
         end
         default: region_code = PH_FULL;
      endcase

      if (w.end_of_input) begin
         if (dec_phase == PH_FULL)
            oc = OUT_TOO_MANY;
         else if (dec_phase != PH_PAYLOAD)
            oc = OUT_TRUNCATED;
         else if (dec_size_sum != dec_paid)
            oc = OUT_SIZE_MISMATCH; // wins over a bad separator
         else if (dec_warn)
            oc = OUT_BAD_SEP;
      end

      r.plain_byte   = p;
      r.region       = region_code;
      r.entry_index  = idx[INDEX_OUT_W-1:0];
      r.entry_done   = done;
      r.entry_size   = esize;
      r.entry_time   = estamp;
      r.payload_last = plast;
      r.magic_ok     = dec_magic_ok;
      r.finished     = w.end_of_input;
      r.outcome      = oc;

      // the last word of an archive starts the next one from scratch
      if (w.end_of_input)
         clear_parse_state();
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= 40)
         $display("cycle %0d result %0d: %s got 0x%0h, expected 0x%0h",
                  cycle_count, results_checked, what, got, want);
   endtask

   // ---------------------------------------------------------------
   // archive generation
   // ---------------------------------------------------------------

   // one archive from dir_sizes, encrypted with the key in force
   task automatic make_archive(input int name_max, input list_end_type end_kind,
                               input int pay_extra, input bit magic_good, input int cut);
      logic [7:0]      plain[$];
      logic [7:0]      sep;
      logic [63:0]     stamp;
      longint unsigned total;
      longint          plen;
      int              bad_pos;
      int              nlen;
      req_type         w;
      bad_pos = magic_good ? -1 : int'($urandom_range(0, MAGIC_LEN - 1));
      for (int i = 0; i < MAGIC_LEN; i++)
         plain = {plain, gen_magic[8*i +: 8] ^
                         ((i == bad_pos) ? 8'($urandom_range(1, 255)) : 8'h00)};
      total = 0;
      foreach (dir_sizes[r]) begin
         plain = {plain, STATUS_NEXT};
         nlen = $urandom_range(0, name_max);
         plain = {plain, 8'(nlen)};
         repeat (nlen) plain = {plain, 8'($urandom)};
         for (int b = 0; b < SIZE_LEN; b++)
            plain = {plain, dir_sizes[r][8*b +: 8]};
         stamp = {$urandom, $urandom};
         for (int b = 0; b < STAMP_LEN; b++)
            plain = {plain, stamp[8*b +: 8]};
         total += dir_sizes[r];
      end
      case (end_kind)
         LIST_CLEAN:   plain = {plain, STATUS_END};
         LIST_BAD_SEP: begin
            do sep = 8'($urandom_range(1, 255)); while (sep == STATUS_END);
            plain = {plain, sep};
         end
         default:      plain = {plain, STATUS_NEXT};
      endcase
      plen = longint'(total) + pay_extra;
      if (plen < 0)
         plen = 0;
      if (plen > PAY_CAP)
         plen = PAY_CAP;
      repeat (plen) plain = {plain, 8'($urandom)};
      if (cut > 0)
         while (plain.size() > cut) void'(plain.pop_back());
      foreach (plain[i]) begin
         w.in_byte      = plain[i] ^ gen_key;
         w.end_of_input = (i == plain.size() - 1);
         archive_bytes_q = {archive_bytes_q, w};
      end
      bytes_queued += plain.size();
      archive_count++;
   endtask

   // raw bytes with end markers scattered about; always closed by one
   task automatic make_noise();
      int      n;
      req_type w;
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
         w.in_byte      = 8'($urandom);
         w.end_of_input = (i == n - 1) || ($urandom_range(0, 15) == 0);
         archive_bytes_q = {archive_bytes_q, w};
      end
      bytes_queued += n;
   endtask

   task automatic make_random_archive();
      int           n_rec;
      int           name_max;
      int           pay_extra;
      int           cut;
      int           pick;
      bit           magic_good;
      list_end_type end_kind;
      dir_sizes.delete();
      n_rec = $urandom_range(0, 4);
      repeat (n_rec) begin
         case ($urandom_range(0, 15))
            0:       dir_sizes = {dir_sizes, 32'h0};
            1:       dir_sizes = {dir_sizes, 32'hFFFF_FFFF};
            2:       dir_sizes = {dir_sizes, 32'($urandom)};
            default: dir_sizes = {dir_sizes, 32'($urandom_range(1, 6))};
         endcase
      end
      pick = $urandom_range(0, 9);
      end_kind   = (pick < 2) ? LIST_BAD_SEP : (pick == 2) ? LIST_MORE : LIST_CLEAN;
      name_max   = ($urandom_range(0, 24) == 0) ? 255 : 4;
      pay_extra  = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 6)) - 3 : 0;
      magic_good = ($urandom_range(0, 5) != 0);
      cut        = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 48)) : 0;
      make_archive(name_max, end_kind, pay_extra, magic_good, cut);
   endtask

   // mostly well-formed archives, about one part in eight noise
   task automatic fill_random(input int count);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < count) begin
         if ($urandom_range(0, 7) == 0)
            make_noise();
         else
            make_random_archive();
      end
   endtask

   // ---------------------------------------------------------------
   // register writes and idle detection, driven on the falling edge
   // ---------------------------------------------------------------
   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] key, input logic [63:0] magic);
      write_csr(CSR_XOR_KEY, {56'h0, key});
      write_csr(CSR_MAGIC, magic);
      gen_key   = key;
      gen_magic = magic;
      settings_used++;
   endtask

   // wait until every queued word went in and every result came back
   task automatic drain_block();
      do @(negedge clock);
      while (archive_bytes_q.size() != 0 || req_valid || decoded_bytes_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // driver: bursts of words with random gaps, some bursts long
   // ---------------------------------------------------------------
   int burst_left = 0;
   int idle_gap   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // the word in hand (if any) went in at the last edge
         if (idle_gap != 0) begin
            idle_gap--;
            req_valid <= 1'b0;
         end else if (archive_bytes_q.size() != 0) begin
            req_data  <= archive_bytes_q.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               idle_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 24);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: stall pattern in stretches of random mode
   // ---------------------------------------------------------------
   int   stall_mode = 0;
   int   stall_left = 0;
   logic stall_bit;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(5, 60);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       stall_bit = 1'b0;                          // no back-pressure
         1:       stall_bit = ($urandom_range(0, 1) == 0);   // half the time
         2:       stall_bit = ($urandom_range(0, 4) != 0);   // mostly stalled
         default: stall_bit = ($urandom_range(0, 7) == 0);   // rare stalls
      endcase
      rsp_stall <= hold_on | stall_bit;
   end

   // one long hold-off while the driver keeps offering words, so the
   // output buffer fills and req_stall must rise
   initial begin : long_hold
      wait (hold_request);
      @(posedge clock);
      hold_on = 1'b1;
      for (int n = 0; n < HOLD_CYCLES; n++)
         @(posedge clock);
      hold_on = 1'b0;
   end

   // ---------------------------------------------------------------
   // monitor: sample handshakes on the rising edge, check and decode
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
         dec_key   = XOR_KEY_RST;
         dec_magic = MAGIC_RST;
         clear_parse_state();
      end else begin
         // results first: a word taken at this edge cannot answer yet
         if (rsp_valid && !rsp_stall) begin
            got_word = rsp_data;
            if (decoded_bytes_q.size() == 0) begin
               report_mismatch("result word with none outstanding", got_word.plain_byte, '0);
            end else begin
               want_word = decoded_bytes_q.pop_front();
               if (got_word.plain_byte !== want_word.plain_byte)
                  report_mismatch("plain_byte", got_word.plain_byte, want_word.plain_byte);
               if (got_word.region !== want_word.region)
                  report_mismatch("region", got_word.region, want_word.region);
               if (got_word.entry_index !== want_word.entry_index)
                  report_mismatch("entry_index", got_word.entry_index, want_word.entry_index);
               if (got_word.entry_done !== want_word.entry_done)
                  report_mismatch("entry_done", got_word.entry_done, want_word.entry_done);
               if (got_word.entry_size !== want_word.entry_size)
                  report_mismatch("entry_size", got_word.entry_size, want_word.entry_size);
               if (got_word.entry_time !== want_word.entry_time)
                  report_mismatch("entry_time", got_word.entry_time, want_word.entry_time);
               if (got_word.payload_last !== want_word.payload_last)
                  report_mismatch("payload_last", got_word.payload_last,
                                  want_word.payload_last);
               if (got_word.magic_ok !== want_word.magic_ok)
                  report_mismatch("magic_ok", got_word.magic_ok, want_word.magic_ok);
               if (got_word.finished !== want_word.finished)
                  report_mismatch("finished", got_word.finished, want_word.finished);
               if (got_word.outcome !== want_word.outcome)
                  report_mismatch("outcome", got_word.outcome, want_word.outcome);
               if (want_word.finished)
                  outcome_seen[want_word.outcome]++;
               results_checked++;
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            decode_archive_byte(req_data, want_word);
            decoded_bytes_q = {decoded_bytes_q, want_word};
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_XOR_KEY: dec_key   = csr_data[7:0];
               CSR_MAGIC:   dec_magic = csr_data;
               default:     ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin : sequencer
      foreach (outcome_seen[i])
         outcome_seen[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed archives under the reset key and magic
      dir_sizes.delete();
      make_archive(3, LIST_CLEAN, 0, 1'b1, 1);      // ends on its first byte
      make_archive(3, LIST_CLEAN, 0, 1'b1, 0);      // empty list, clean end
      make_archive(3, LIST_BAD_SEP, 0, 1'b0, 0);    // empty list, odd status, bad header
      dir_sizes = '{32'd0, 32'd2, 32'd0, 32'd1};    // zero-size files at the start and in between
      make_archive(3, LIST_CLEAN, 0, 1'b1, 0);
      dir_sizes = '{32'd1};
      make_archive(0, LIST_CLEAN, 2, 1'b1, 0);      // payload past the last file
      dir_sizes = '{32'hFFFF_FFFF};
      make_archive(0, LIST_CLEAN, 0, 1'b1, 0);      // largest size field
      dir_sizes = '{32'd3};
      make_archive(2, LIST_BAD_SEP, 0, 1'b1, 0);    // sums agree, separator warning
      make_archive(2, LIST_BAD_SEP, 1, 1'b1, 0);    // mismatch outranks the warning
      dir_sizes = '{32'd2};
      make_archive(3, LIST_CLEAN, 0, 1'b1, 15);     // cut inside the record
      make_archive(0, LIST_CLEAN, -1, 1'b1, 0);     // payload one byte short
      drain_block();

      // extremes of key and magic, then random settings
      apply_settings(8'h00, 64'h0);
      fill_random(RANDOM_PER_PHASE);
      hold_request = 1'b1;
      drain_block();
      apply_settings(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
      fill_random(RANDOM_PER_PHASE);
      drain_block();
      repeat (2) begin
         apply_settings(8'($urandom), {$urandom, $urandom});
         fill_random(RANDOM_PER_PHASE);
         drain_block();
      end

      $display("Covered %0d archives, %0d words, %0d results under %0d key/magic settings",
               archive_count, bytes_queued, results_checked, settings_used);
      $display("Outcomes: ok %0d, separator %0d, size mismatch %0d, too many %0d, truncated %0d",
               outcome_seen[OUT_OK], outcome_seen[OUT_BAD_SEP], outcome_seen[OUT_SIZE_MISMATCH],
               outcome_seen[OUT_TOO_MANY], outcome_seen[OUT_TRUNCATED]);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- xor_archive_directory_parser.f -----
hw/rtl/xadp_pkg.sv
hw/rtl/xadp_file_walk.sv
hw/rtl/xor_archive_directory_parser.sv
dv/xor_archive_directory_parser_test.sv
